// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MQRF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define MQRF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/mqrf_pkg.sv =====
// types, sizes and codes of the multi-queue ring fifo
package mqrf_pkg;

  localparam int QUEUES = 4;
  localparam int DEPTH  = 16;

  localparam int QSEL_W = 2;
  localparam int WORD_W = 32;
  localparam int HELD_W = 4;
  localparam int DROP_W = 16;

  localparam int Q_W    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int SA_W   = ((QUEUES * DEPTH) > 1) ? $clog2(QUEUES * DEPTH) : 1;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0]  CNT_MAX  = PTR_W'(DEPTH - 1);
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DONE
  } state_t;

  // per-queue descriptor, one entry of the descriptor memory
  typedef struct packed {
    logic [DROP_W-1:0] drop;
    logic [PTR_W-1:0]  cnt;
    logic [PTR_W-1:0]  wp;
    logic [PTR_W-1:0]  rp;
  } desc_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== rtl/mqrf_ram.sv =====
// generic simple dual-port ram with registered read
module mqrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/multi_queue_ring_fifo_top.sv =====
// top level of the multi-queue ring fifo
// several independent ring fifos of 32-bit words share one word memory; each
// queue has DEPTH slots and holds at most DEPTH-1 words. one input item clears
// a queue, appends a word or removes the oldest word, and always yields one
// result item with the removed word (zero unless a read succeeded), a status
// (ok, full with the write dropped, or empty read), the words now held and the
// queue's saturating count of dropped writes. each item is handled in steps:
// the queue descriptor is read from its memory, then updated and written back
// while the word memory is written or read, then the result is formed from the
// word memory's read data. the result sits in an output register, so the next
// item is taken while a finished result still waits on out_stall. the descriptor
// memory has one valid flop per queue cleared at reset, so no clearing pass is
// needed; the word memory has no reset and is only read at slots
// already written
`include "assert_macros.svh"

module multi_queue_ring_fifo_top (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [mqrf_pkg::QSEL_W-1:0] queue_select,
  input  logic [mqrf_pkg::WORD_W-1:0] write_word,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mqrf_pkg::WORD_W-1:0] read_word,
  output logic [1:0]                  status,
  output logic [mqrf_pkg::HELD_W-1:0] held_count,
  output logic [mqrf_pkg::DROP_W-1:0] lost_count
);

  // control
  mqrf_pkg::state_t state, state_next;
  logic in_acc;
  logic out_load;

  // request held for the update cycle
  logic [1:0]                  req_r;
  logic [mqrf_pkg::QSEL_W-1:0] qsel_r;
  logic [mqrf_pkg::WORD_W-1:0] data_r;
  logic [mqrf_pkg::Q_W-1:0]    q_idx;
  logic                        q_ok;

  // descriptor memory and its valid flops
  logic [mqrf_pkg::QUEUES-1:0] desc_vld;
  logic                        desc_we;
  logic                        desc_re;
  logic [mqrf_pkg::Q_W-1:0]    desc_raddr;
  mqrf_pkg::desc_t             desc_rdata;
  mqrf_pkg::desc_t             cur;
  mqrf_pkg::desc_t             desc_wdata;

  // word memory
  logic                        store_we;
  logic                        store_re;
  logic [mqrf_pkg::SA_W-1:0]   store_waddr;
  logic [mqrf_pkg::SA_W-1:0]   store_raddr;
  logic [mqrf_pkg::WORD_W-1:0] store_rdata;

  // result of the update cycle
  logic                        wr_ok;
  logic                        rd_ok;
  logic [1:0]                  st_c;
  logic                        res_rd;
  logic [1:0]                  res_status;
  logic [mqrf_pkg::HELD_W-1:0] res_held;
  logic [mqrf_pkg::DROP_W-1:0] res_lost;

  assign in_acc = in_valid && !in_stall;

  assign q_idx = mqrf_pkg::Q_W'(qsel_r);
  assign q_ok  = (32'(qsel_r) < 32'(mqrf_pkg::QUEUES));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mqrf_pkg::S_IDLE: if (in_acc) state_next = mqrf_pkg::S_LOOK;
      mqrf_pkg::S_LOOK: state_next = mqrf_pkg::S_DONE;
      mqrf_pkg::S_DONE: if (out_load) state_next = mqrf_pkg::S_IDLE;
      default:          state_next = mqrf_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = (state != mqrf_pkg::S_IDLE);
    desc_re    = 1'b0;
    desc_raddr = mqrf_pkg::Q_W'(queue_select);
    desc_we    = 1'b0;
    store_we   = 1'b0;
    store_re   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      mqrf_pkg::S_IDLE: desc_re = in_valid;
      mqrf_pkg::S_LOOK: begin
        desc_we  = q_ok;
        store_we = q_ok && wr_ok;
        store_re = q_ok && rd_ok;
      end
      mqrf_pkg::S_DONE: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqrf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= req_type;
      qsel_r <= queue_select;
      data_r <= write_word;
    end
  end

  // a descriptor never written reads as zero
  always_comb begin
    cur = '0;
    if (q_ok && desc_vld[q_idx]) begin
      cur = desc_rdata;
    end
  end

  // descriptor update
  always_comb begin
    desc_wdata = cur;
    wr_ok      = 1'b0;
    rd_ok      = 1'b0;
    st_c       = mqrf_pkg::ST_OK;
    unique case (req_r)
      mqrf_pkg::REQ_CLEAR: desc_wdata = '0;
      mqrf_pkg::REQ_WRITE: begin
        if (cur.cnt == mqrf_pkg::CNT_MAX) begin
          st_c = mqrf_pkg::ST_FULL;
          if (cur.drop != mqrf_pkg::DROP_MAX) begin
            desc_wdata.drop = cur.drop + mqrf_pkg::DROP_W'(1);
          end
        end else begin
          wr_ok         = 1'b1;
          desc_wdata.wp = mqrf_pkg::next_slot(cur.wp);
          desc_wdata.cnt = cur.cnt + mqrf_pkg::PTR_W'(1);
        end
      end
      mqrf_pkg::REQ_READ: begin
        if (cur.cnt == '0) begin
          st_c = mqrf_pkg::ST_EMPTY;
        end else begin
          rd_ok          = 1'b1;
          desc_wdata.rp  = mqrf_pkg::next_slot(cur.rp);
          desc_wdata.cnt = cur.cnt - mqrf_pkg::PTR_W'(1);
        end
      end
      default: ;
    endcase
  end

  // queue q owns slots q*DEPTH up to q*DEPTH+DEPTH-1
  assign store_waddr = mqrf_pkg::SA_W'(q_idx) * mqrf_pkg::SA_W'(mqrf_pkg::DEPTH)
                     + mqrf_pkg::SA_W'(cur.wp);
  assign store_raddr = mqrf_pkg::SA_W'(q_idx) * mqrf_pkg::SA_W'(mqrf_pkg::DEPTH)
                     + mqrf_pkg::SA_W'(cur.rp);

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_vld <= '0;
    end else if (desc_we) begin
      desc_vld[q_idx] <= 1'b1;
    end
  end

  // result fields captured in the update cycle; an out-of-range queue gives zeros
  always_ff @(posedge clk) begin
    if (state == mqrf_pkg::S_LOOK) begin
      res_rd     <= q_ok && rd_ok;
      res_status <= q_ok ? st_c : mqrf_pkg::ST_OK;
      res_held   <= q_ok ? mqrf_pkg::HELD_W'(desc_wdata.cnt) : '0;
      res_lost   <= q_ok ? desc_wdata.drop : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_word  <= res_rd ? store_rdata : '0;
      status     <= res_status;
      held_count <= res_held;
      lost_count <= res_lost;
    end
  end

  mqrf_ram #(
    .WIDTH($bits(mqrf_pkg::desc_t)),
    .DEPTH(mqrf_pkg::QUEUES)
  ) u_desc_ram (
    .clk    (clk),
    .wr_en  (desc_we),
    .wr_addr(q_idx),
    .wr_data(desc_wdata),
    .rd_en  (desc_re),
    .rd_addr(desc_raddr),
    .rd_data(desc_rdata)
  );

  mqrf_ram #(
    .WIDTH(mqrf_pkg::WORD_W),
    .DEPTH(mqrf_pkg::QUEUES * mqrf_pkg::DEPTH)
  ) u_word_ram (
    .clk    (clk),
    .wr_en  (store_we),
    .wr_addr(store_waddr),
    .wr_data(data_r),
    .rd_en  (store_re),
    .rd_addr(store_raddr),
    .rd_data(store_rdata)
  );

  // an accepted item always moves on to the update cycle
  `MQRF_ASSERT_NXT(a_accept_look, clk, rst, in_acc, state == mqrf_pkg::S_LOOK)
  // a queue never records more than DEPTH-1 words
  `MQRF_ASSERT_IMP(a_cnt_bound, clk, rst, desc_we, desc_wdata.cnt <= mqrf_pkg::CNT_MAX)
  // a word is stored only for a write request that found room
  `MQRF_ASSERT_IMP(a_store_write, clk, rst, store_we,
                   req_r == mqrf_pkg::REQ_WRITE && st_c == mqrf_pkg::ST_OK)
  // a failed request returns no data
  `MQRF_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && status != mqrf_pkg::ST_OK,
                   read_word == '0)

endmodule

// ===== dv/multi_queue_ring_fifo_top_tb.sv =====
// testbench of the multi-queue ring fifo: predicting scoreboard, random bursts and stalls
`timescale 1ns / 1ps

module multi_queue_ring_fifo_top_tb;
  import mqrf_pkg::*;

  // the one request code the block leaves unused
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // idle tail after the final drain, before the verdict is printed
  localparam int SETTLE_CYCLES = 10;
  // hard stop limit for about 1050 items, even with long gaps and stalls
  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 1000;
  // writes sent to an already full ring in the back-to-back section
  localparam int OVERFLOW_ITEMS = 8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        status;
    logic [HELD_W-1:0] held;
    logic [DROP_W-1:0] lost;
  } ring_reply_t;

  // mirror of every ring plus the replies still owed by the block
  class ring_fifo_predictor;
    logic [WORD_W-1:0] slot_word [QUEUES][DEPTH];
    int                head [QUEUES];
    int                tail [QUEUES];
    int                fill [QUEUES];
    int                dropped [QUEUES];
    ring_reply_t       owed_replies [$];
    int unsigned       mismatches;

    function new();
      for (int q = 0; q < QUEUES; q++) begin
        head[q] = 0;
        tail[q] = 0;
        fill[q] = 0;
        dropped[q] = 0;
      end
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    // work out the reply of one accepted request and update the rings
    function void note_request(logic [1:0] kind, logic [QSEL_W-1:0] sel,
                               logic [WORD_W-1:0] data);
      ring_reply_t r;
      int q;
      r = '0;
      r.status = ST_OK;
      q = int'(sel);
      if (q >= QUEUES) begin
        owed_replies.push_back(r);
        return;
      end
      case (kind)
        REQ_CLEAR: begin
          head[q] = 0;
          tail[q] = 0;
          fill[q] = 0;
          dropped[q] = 0;
        end
        REQ_WRITE: begin
          if (fill[q] >= DEPTH - 1) begin
            if (dropped[q] < (1 << DROP_W) - 1) dropped[q]++;
            r.status = ST_FULL;
          end else begin
            slot_word[q][tail[q]] = data;
            tail[q] = (tail[q] + 1) % DEPTH;
            fill[q]++;
          end
        end
        REQ_READ: begin
          if (fill[q] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.word = slot_word[q][head[q]];
            head[q] = (head[q] + 1) % DEPTH;
            fill[q]--;
          end
        end
        default: ;
      endcase
      r.held = HELD_W'(fill[q]);
      r.lost = DROP_W'(dropped[q]);
      owed_replies.push_back(r);
    endfunction

    function void check_reply(logic [WORD_W-1:0] word, logic [1:0] st,
                              logic [HELD_W-1:0] held, logic [DROP_W-1:0] lost);
      ring_reply_t e;
      if (owed_replies.size() == 0) begin
        $error("result item with nothing expected: read_word %h status %0d", word, st);
        mismatches++;
        return;
      end
      e = owed_replies.pop_front();
      if (word !== e.word) begin
        $error("read_word: expected %h, got %h", e.word, word);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        mismatches++;
      end
      if (held !== e.held) begin
        $error("held_count: expected %0d, got %0d", e.held, held);
        mismatches++;
      end
      if (lost !== e.lost) begin
        $error("lost_count: expected %0d, got %0d", e.lost, lost);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type = REQ_CLEAR;
  logic [QSEL_W-1:0]   queue_select = '0;
  logic [WORD_W-1:0]   write_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [WORD_W-1:0]   read_word;
  logic [1:0]          status;
  logic [HELD_W-1:0]   held_count;
  logic [DROP_W-1:0]   lost_count;

  ring_fifo_predictor predictor = new();

  // when set, the sender runs without gaps and the receiver never stalls
  bit steady_flow = 1'b0;
  int burst_left  = 0;
  int cycle_count = 0;

  multi_queue_ring_fifo_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .queue_select (queue_select),
    .write_word   (write_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_word    (read_word),
    .status       (status),
    .held_count   (held_count),
    .lost_count   (lost_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_queue_ring_fifo_top_tb: errors");
      $finish;
    end
  end

  // result side: check what was taken at this edge, then pick the next stall level
  // stall and free stretches alternate, with their lengths drawn afresh each time
  bit stall_on  = 1'b0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      predictor.check_reply(read_word, status, held_count, lost_count);
    if (steady_flow) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      if (stall_run == 0) begin
        stall_on = !stall_on;
        // long free stretches now and then, so the block also runs unhindered
        stall_run = stall_on ? $urandom_range(1, 6)
                             : (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8));
      end
      out_stall <= stall_on;
      stall_run--;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_request(input logic [1:0] kind, input logic [QSEL_W-1:0] sel,
                              input logic [WORD_W-1:0] data);
    in_valid     <= 1'b1;
    req_type     <= kind;
    queue_select <= sel;
    write_word   <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.note_request(kind, sel, data);
    // sender bursts: when a burst runs out, drop valid for a random gap
    if (!steady_flow) begin
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 25 : 5)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the sender back until the block owes nothing
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int write_share;
    int focus_queue;
    int roll;
    logic [1:0] kind;
    logic [QSEL_W-1:0] sel;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty read, unused code, clear, extreme words
    send_request(REQ_READ, QSEL_W'(0), '0);
    send_request(REQ_UNUSED, QSEL_W'(2), 32'h5a5a_a5a5);
    send_request(REQ_CLEAR, QSEL_W'(1), '1);
    send_request(REQ_WRITE, QSEL_W'(3), '0);
    send_request(REQ_WRITE, QSEL_W'(3), '1);
    send_request(REQ_READ, QSEL_W'(3), '0);
    send_request(REQ_READ, QSEL_W'(3), '0);
    // fill queue 0 to its limit, then overflow it twice
    for (int i = 0; i < DEPTH + 1; i++)
      send_request(REQ_WRITE, QSEL_W'(0), WORD_W'(32'h1) << i);
    send_request(REQ_READ, QSEL_W'(0), '0);
    send_request(REQ_CLEAR, QSEL_W'(0), '0);
    drain_results();

    // back to back on queue 2: fill it, overflow it a few times, then clear
    steady_flow = 1'b1;
    for (int i = 0; i < DEPTH - 1; i++)
      send_request(REQ_WRITE, QSEL_W'(2), pick_word());
    for (int i = 0; i < OVERFLOW_ITEMS; i++)
      send_request(REQ_WRITE, QSEL_W'(2), pick_word());
    send_request(REQ_READ, QSEL_W'(2), '0);
    send_request(REQ_UNUSED, QSEL_W'(2), '0);
    send_request(REQ_CLEAR, QSEL_W'(2), '0);
    drain_results();
    steady_flow = 1'b0;

    // random: phases lean towards writes or reads so rings fill, wrap and empty
    write_share = 50;
    focus_queue = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       write_share = 25;
          1:       write_share = 50;
          default: write_share = 80;
        endcase
        focus_queue = $urandom_range(0, QUEUES - 1);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2)                   kind = REQ_CLEAR;
      else if (roll < 4)              kind = REQ_UNUSED;
      else if ($urandom_range(0, 99) < write_share) kind = REQ_WRITE;
      else                            kind = REQ_READ;
      sel = ($urandom_range(0, 9) < 7) ? QSEL_W'(focus_queue)
                                       : QSEL_W'($urandom_range(0, (1 << QSEL_W) - 1));
      send_request(kind, sel, pick_word());
      // now and then let everything in flight come back before going on
      if (n % 250 == 249) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.pending() == 0)
      $display("multi_queue_ring_fifo_top_tb: clean");
    else
      $display("multi_queue_ring_fifo_top_tb: errors");
    $finish;
  end

endmodule
